// ===== rtl/core/sdpu_pkg.sv =====
// shared types and constants for the segment descriptor protection unit
// request/response structs, descriptor layout, op codes and attribute bit positions
// no dependencies
package sdpu_pkg;

    localparam int IDX_W   = 8;
    localparam int LIMIT_W = 20;
    localparam int ATTR_W  = 9;
    localparam int DATA_W  = 32;

    localparam logic [3:0] OP_WR_LIMIT = 4'd0;
    localparam logic [3:0] OP_WR_BASE  = 4'd1;
    localparam logic [3:0] OP_WR_ATTR  = 4'd2;
    localparam logic [3:0] OP_ACCESS   = 4'd3;
    localparam logic [3:0] OP_READ     = 4'd4;
    localparam logic [3:0] OP_WRITE    = 4'd5;
    localparam logic [3:0] OP_EXECUTE  = 4'd6;
    localparam logic [3:0] OP_TO_FLAT  = 4'd7;
    localparam logic [3:0] OP_FROM_FLAT = 4'd8;

    localparam int ATTR_RW      = 1;
    localparam int ATTR_CONF    = 2;
    localparam int ATTR_CODE    = 3;
    localparam int ATTR_DPL_LO  = 4;
    localparam int ATTR_PRESENT = 6;
    localparam int ATTR_GRAN    = 8;

    localparam logic [DATA_W-1:0] BYTE_LIMIT_MAX = 32'h000F_FFFF;
    localparam logic [11:0]       PAGE_FILL      = 12'hFFF;

    typedef struct packed {
        logic [3:0]        op;
        logic [IDX_W-1:0]  index;
        logic [IDX_W-1:0]  current_index;
        logic [DATA_W-1:0] value;
        logic              use_offset;
        logic [ATTR_W-1:0] attributes;
    } t_req;

    typedef struct packed {
        logic              allowed;
        logic [DATA_W-1:0] value_out;
    } t_rsp;

    typedef struct packed {
        logic [ATTR_W-1:0]  attr;
        logic [DATA_W-1:0]  base;
        logic [LIMIT_W-1:0] limit;
    } t_desc;

    typedef struct packed {
        logic  wr_en;
        t_desc desc;
    } t_upd;

endpackage

// ===== rtl/core/segment_descriptor_protection_unit.sv =====
// top level of the segment descriptor protection unit
// descriptor memory, read stage with write forwarding, response register
// depends on sdpu_pkg and sdpu_eval
//
// Takes one request per cycle when the response side keeps up. The edge that
// accepts a request reads the descriptor memory at index and current_index;
// when the read stage advances, the request is evaluated, the entry written
// back and the response register loaded. A write that lands on an entry read
// by the very next request is forwarded. After reset the block clears the
// descriptor memory, one entry a cycle, and holds o_req_stall high until
// every entry is cleared. Indexes at or above ENTRIES read as an all-zero
// descriptor and ignore writes.
module segment_descriptor_protection_unit #(
    parameter int ENTRIES = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  sdpu_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output sdpu_pkg::t_rsp  o_rsp
);
    import sdpu_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int WW = AW + IDX_W;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    t_state  r_state, n_state;
    logic [AW-1:0] r_clr_addr;

    t_desc   r_mem [ENTRIES];
    t_desc   r_rd_idx;
    t_desc   r_rd_cur;

    logic    r_s1_valid;
    t_req    r_s1_req;
    logic [AW-1:0] r_s1_addr;
    logic    r_s1_idx_ok;
    logic    r_s1_cur_ok;
    logic    r_fwd_idx;
    logic    r_fwd_cur;
    t_desc   r_fwd_data;

    logic    r_rsp_valid;
    t_rsp    r_rsp;

    logic [WW-1:0] idx_wide;
    logic [WW-1:0] cur_wide;
    logic [AW-1:0] idx_addr;
    logic [AW-1:0] cur_addr;
    logic    idx_ok;
    logic    cur_ok;
    logic    accept;
    logic    s1_adv;
    logic    wr_fire;
    logic    mem_we;
    logic [AW-1:0] mem_wa;
    t_desc   mem_wd;
    t_desc   s1_desc;
    t_desc   s1_cur;
    t_rsp    eval_rsp;
    t_upd    eval_upd;

    assign idx_wide = WW'(i_req.index);
    assign cur_wide = WW'(i_req.current_index);
    assign idx_addr = idx_wide[AW-1:0];
    assign cur_addr = cur_wide[AW-1:0];
    assign idx_ok   = idx_wide < WW'(ENTRIES);
    assign cur_ok   = cur_wide < WW'(ENTRIES);

    assign s1_adv      = r_s1_valid && (!r_rsp_valid || !i_rsp_stall);
    assign o_req_stall = (r_state != ST_RUN) || (r_s1_valid && !s1_adv);
    assign accept      = i_req_valid && !o_req_stall;

    // forwarded write wins over stale read data
    assign s1_desc = !r_s1_idx_ok ? '0 : (r_fwd_idx ? r_fwd_data : r_rd_idx);
    assign s1_cur  = !r_s1_cur_ok ? '0 : (r_fwd_cur ? r_fwd_data : r_rd_cur);

    sdpu_eval u_eval (
        .i_req      (r_s1_req),
        .i_desc     (s1_desc),
        .i_cur_attr (s1_cur.attr),
        .i_idx_ok   (r_s1_idx_ok),
        .o_rsp      (eval_rsp),
        .o_upd      (eval_upd)
    );

    assign wr_fire = s1_adv && eval_upd.wr_en;

    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else begin
            mem_we = wr_fire;
            mem_wa = r_s1_addr;
            mem_wd = eval_upd.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (accept) begin
            r_rd_idx <= r_mem[idx_addr];
            r_rd_cur <= r_mem[cur_addr];
        end
    end

    always_comb begin
        case (r_state)
            ST_CLEAR: n_state = (r_clr_addr == AW'(ENTRIES - 1)) ? ST_RUN : ST_CLEAR;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req    <= i_req;
            r_s1_addr   <= idx_addr;
            r_s1_idx_ok <= idx_ok;
            r_s1_cur_ok <= cur_ok;
            r_fwd_idx   <= wr_fire && (r_s1_addr == idx_addr);
            r_fwd_cur   <= wr_fire && (r_s1_addr == cur_addr);
            r_fwd_data  <= eval_upd.desc;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (s1_adv) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_rsp <= eval_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== rtl/core/sdpu_eval.sv =====
// per-request evaluation: protection checks, translation and descriptor update
// depends on sdpu_pkg
module sdpu_eval (
    input  sdpu_pkg::t_req               i_req,
    input  sdpu_pkg::t_desc              i_desc,
    input  logic [sdpu_pkg::ATTR_W-1:0]  i_cur_attr,
    input  logic                         i_idx_ok,
    output sdpu_pkg::t_rsp               o_rsp,
    output sdpu_pkg::t_upd               o_upd
);
    import sdpu_pkg::*;

    logic                gran_set;
    logic [LIMIT_W-1:0]  new_limit;
    logic [DATA_W-1:0]   byte_limit;
    logic [1:0]          cpl;
    logic [1:0]          dpl;
    logic                is_code;
    logic                is_rw;
    logic                base_ok;
    logic                type_ok;

    assign gran_set  = i_req.value > BYTE_LIMIT_MAX;
    assign new_limit = gran_set ? i_req.value[DATA_W-1:12] : i_req.value[LIMIT_W-1:0];

    assign byte_limit = i_desc.attr[ATTR_GRAN] ? {i_desc.limit, PAGE_FILL}
                                               : {12'b0, i_desc.limit};

    assign cpl     = i_cur_attr[ATTR_DPL_LO+1:ATTR_DPL_LO];
    assign dpl     = i_desc.attr[ATTR_DPL_LO+1:ATTR_DPL_LO];
    assign is_code = i_desc.attr[ATTR_CODE];
    assign is_rw   = i_desc.attr[ATTR_RW];

    // limit, present and privilege rules
    assign base_ok = !(i_req.use_offset && (byte_limit < i_req.value))
                     && i_desc.attr[ATTR_PRESENT]
                     && !(is_code && !i_desc.attr[ATTR_CONF] && (dpl != cpl))
                     && !(dpl < cpl);

    always_comb begin
        case (i_req.op)
            OP_READ:    type_ok = !(is_code && !is_rw);
            OP_WRITE:   type_ok = !is_code && is_rw;
            OP_EXECUTE: type_ok = is_code;
            default:    type_ok = 1'b1;
        endcase
    end

    always_comb begin
        o_rsp       = '0;
        o_upd.wr_en = 1'b0;
        o_upd.desc  = i_desc;
        case (i_req.op)
            OP_WR_LIMIT: begin
                o_upd.wr_en                = i_idx_ok;
                o_upd.desc.limit           = new_limit;
                o_upd.desc.attr[ATTR_GRAN] = gran_set;
                o_rsp.value_out            = {12'b0, new_limit};
            end
            OP_WR_BASE: begin
                o_upd.wr_en     = i_idx_ok;
                o_upd.desc.base = i_req.value;
            end
            OP_WR_ATTR: begin
                o_upd.wr_en     = i_idx_ok;
                o_upd.desc.attr = i_req.attributes;
            end
            OP_ACCESS, OP_READ, OP_WRITE, OP_EXECUTE: begin
                o_rsp.allowed   = base_ok && type_ok;
                o_rsp.value_out = byte_limit;
            end
            OP_TO_FLAT: begin
                o_rsp.value_out = i_req.value + i_desc.base;
            end
            OP_FROM_FLAT: begin
                o_rsp.value_out = i_req.value - i_desc.base;
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/sdpu_checker.sv =====
// port-level checks for the segment descriptor protection unit
// depends on sdpu_pkg; bound to the top level at the end of this file
module sdpu_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            o_req_stall,
    input  logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    input  sdpu_pkg::t_rsp  o_rsp
);
    import sdpu_pkg::*;

    // table clear blocks requests right after reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_req_stall)
        else $error("request side not stalled after reset");

    // no response may come out of reset
    a_no_rsp_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid right after reset");

    a_rsp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> $stable(o_rsp))
        else $error("response changed while stalled");

endmodule

bind segment_descriptor_protection_unit sdpu_checker u_sdpu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_req_stall (o_req_stall),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// testbench for segment_descriptor_protection_unit: directed and random requests,
// a descriptor table model predicts every response, the monitor checks them in order
// depends on sdpu_pkg and the rtl top level
module tb;
    import sdpu_pkg::*;

    localparam int          TABLE_DEPTH     = 256;
    localparam int          RANDOM_REQS     = 1400;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          MAX_PRINTS      = 40;
    localparam realtime     TIMEOUT_NS      = 1_600_000.0;
    localparam logic [3:0]  OP_UNUSED_LO    = 4'd9;
    localparam logic [3:0]  OP_UNUSED_HI    = 4'd15;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   req_valid = 1'b0;
    logic   rsp_stall = 1'b0;
    t_req   req       = '0;
    logic   o_req_stall;
    logic   o_rsp_valid;
    t_rsp   o_rsp;

    t_req   pending_reqs[$];
    t_rsp   expected_rsp[$];
    int     n_accepted = 0;
    int     n_errors   = 0;
    logic   calm;

    logic [LIMIT_W-1:0] desc_limit [TABLE_DEPTH];
    logic [DATA_W-1:0]  desc_base  [TABLE_DEPTH];
    logic [ATTR_W-1:0]  desc_attr  [TABLE_DEPTH];

    segment_descriptor_protection_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (o_rsp)
    );

    always #2 i_clk = ~i_clk;

    // stretch of requests with no idling on either side
    assign calm = (n_accepted >= 600) && (n_accepted < 900);

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTS) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        n_errors++;
    endtask

    function automatic logic [DATA_W-1:0] entry_byte_limit(input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] lim;
        lim = DATA_W'(desc_limit[idx]);
        if (desc_attr[idx][ATTR_GRAN]) begin
            return {lim[DATA_W-13:0], PAGE_FILL};
        end
        return lim;
    endfunction

    function automatic logic check_permits(input t_req r);
        logic [ATTR_W-1:0] a;
        logic [1:0]        dpl;
        logic [1:0]        cpl;
        logic              code;
        logic              rw;
        a    = desc_attr[r.index];
        dpl  = a[ATTR_DPL_LO +: 2];
        cpl  = desc_attr[r.current_index][ATTR_DPL_LO +: 2];
        code = a[ATTR_CODE];
        rw   = a[ATTR_RW];
        if (r.use_offset && entry_byte_limit(r.index) < r.value) return 1'b0;
        if (!a[ATTR_PRESENT]) return 1'b0;
        if (code && !a[ATTR_CONF] && dpl != cpl) return 1'b0;
        if (dpl < cpl) return 1'b0;
        case (r.op)
            OP_READ:    if (code && !rw) return 1'b0;
            OP_WRITE:   if (code || !rw) return 1'b0;
            OP_EXECUTE: if (!code) return 1'b0;
            default: ;
        endcase
        return 1'b1;
    endfunction

    task automatic predict_response(input t_req r);
        t_rsp               rsp;
        logic               gran;
        logic [DATA_W-1:0]  lim;
        rsp = '0;
        case (r.op)
            OP_WR_LIMIT: begin
                gran = r.value > BYTE_LIMIT_MAX;
                lim  = gran ? (r.value >> 12) : r.value;
                lim  = lim & BYTE_LIMIT_MAX;
                desc_limit[r.index] = lim[LIMIT_W-1:0];
                desc_attr[r.index][ATTR_GRAN] = gran;
                rsp.value_out = lim;
            end
            OP_WR_BASE:   desc_base[r.index] = r.value;
            OP_WR_ATTR:   desc_attr[r.index] = r.attributes;
            OP_ACCESS, OP_READ, OP_WRITE, OP_EXECUTE: begin
                rsp.allowed   = check_permits(r);
                rsp.value_out = entry_byte_limit(r.index);
            end
            OP_TO_FLAT:   rsp.value_out = r.value + desc_base[r.index];
            OP_FROM_FLAT: rsp.value_out = r.value - desc_base[r.index];
            default: ;
        endcase
        expected_rsp.push_back(rsp);
    endtask

    task automatic queue_request(input logic [3:0] op, input int idx, input int cur,
                                 input logic [DATA_W-1:0] val, input logic use_off,
                                 input logic [ATTR_W-1:0] attr);
        t_req r;
        r.op            = op;
        r.index         = IDX_W'(idx);
        r.current_index = IDX_W'(cur);
        r.value         = val;
        r.use_offset    = use_off;
        r.attributes    = attr;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [IDX_W-1:0] pick_entry();
        if ($urandom_range(99) < 75) return IDX_W'($urandom_range(0, 7));
        return IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || !o_req_stall) begin
            if (req_valid) begin
                predict_response(req);
                n_accepted++;
            end
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
                req_valid <= 1'b1;
                req       <= pending_reqs.pop_front();
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            rsp_stall <= 1'b0;
        end else begin
            if (o_rsp_valid && !rsp_stall) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    exp_rsp = expected_rsp.pop_front();
                    if (o_rsp.allowed !== exp_rsp.allowed) begin
                        report_mismatch($sformatf("allowed %b, expected %b",
                                                  o_rsp.allowed, exp_rsp.allowed));
                    end
                    if (o_rsp.value_out !== exp_rsp.value_out) begin
                        report_mismatch($sformatf("value_out %h, expected %h",
                                                  o_rsp.value_out, exp_rsp.value_out));
                    end
                end
            end
            rsp_stall <= !calm && ($urandom_range(99) < 20);
        end
    end

    initial begin
        t_req r;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            desc_limit[i] = '0;
            desc_base[i]  = '0;
            desc_attr[i]  = '0;
        end

        // cleared entry, limit extremes, granularity, wrapping translations
        queue_request(OP_ACCESS,    0,   0,   32'h0000_0000, 1'b1, 9'h000);
        queue_request(OP_WR_LIMIT,  1,   0,   32'h000F_FFFF, 1'b0, 9'h000);
        queue_request(OP_WR_ATTR,   1,   0,   32'h0000_0000, 1'b0, 9'h072);
        queue_request(OP_WR_LIMIT,  1,   0,   32'h0010_0000, 1'b0, 9'h000);
        queue_request(OP_WRITE,     1,   1,   32'h0010_0FFF, 1'b1, 9'h000);
        queue_request(OP_READ,      1,   1,   32'h0010_1000, 1'b1, 9'h000);
        queue_request(OP_WR_LIMIT,  2,   0,   32'hFFFF_FFFF, 1'b0, 9'h000);
        queue_request(OP_WR_BASE,   2,   0,   32'hFFFF_FFFF, 1'b0, 9'h000);
        queue_request(OP_TO_FLAT,   2,   0,   32'h0000_0001, 1'b0, 9'h000);
        queue_request(OP_FROM_FLAT, 2,   0,   32'h0000_0000, 1'b0, 9'h000);
        // non-conforming execute-only code, conforming code, privilege levels
        queue_request(OP_WR_ATTR,   3,   0,   32'h0000_0000, 1'b0, 9'h048);
        queue_request(OP_EXECUTE,   3,   3,   32'h0000_0000, 1'b0, 9'h000);
        queue_request(OP_READ,      3,   3,   32'h0000_0000, 1'b0, 9'h000);
        queue_request(OP_WRITE,     3,   3,   32'h0000_0000, 1'b0, 9'h000);
        queue_request(OP_EXECUTE,   3,   1,   32'h0000_0000, 1'b0, 9'h000);
        queue_request(OP_WR_ATTR,   4,   0,   32'h0000_0000, 1'b0, 9'h07E);
        queue_request(OP_READ,      4,   1,   32'h0000_0000, 1'b0, 9'h000);
        queue_request(OP_WR_ATTR,   5,   0,   32'h0000_0000, 1'b0, 9'h042);
        queue_request(OP_WRITE,     5,   1,   32'h0000_0000, 1'b0, 9'h000);
        queue_request(OP_WRITE,     5,   5,   32'h0000_0000, 1'b0, 9'h000);
        queue_request(OP_WR_ATTR,   255, 0,   32'h0000_0000, 1'b0, 9'h1FF);
        queue_request(OP_ACCESS,    255, 255, 32'hFFFF_FFFF, 1'b1, 9'h000);
        queue_request(OP_WR_LIMIT,  255, 0,   32'h0000_0000, 1'b0, 9'h000);
        queue_request(OP_UNUSED_LO, 6,   6,   32'hFFFF_FFFF, 1'b1, 9'h1FF);
        queue_request(OP_UNUSED_HI, 7,   7,   32'hFFFF_FFFF, 1'b1, 9'h1FF);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if ($urandom_range(99) < 5) begin
                r.op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            end else begin
                r.op = 4'($urandom_range(OP_WR_LIMIT, OP_FROM_FLAT));
            end
            r.index         = pick_entry();
            r.current_index = pick_entry();
            case ($urandom_range(0, 4))
                0:       r.value = DATA_W'($urandom_range(0, 32'h000F_FFFF));
                1:       r.value = 32'h000F_FFFF;
                2:       r.value = 32'h0010_0000;
                3:       r.value = 32'hFFFF_FFFF;
                default: r.value = $urandom();
            endcase
            r.use_offset = 1'($urandom_range(0, 1));
            r.attributes = ATTR_W'($urandom_range(0, 511));
            if ($urandom_range(99) < 80) r.attributes[ATTR_PRESENT] = 1'b1;
            pending_reqs.push_back(r);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || req_valid || expected_rsp.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/sdpu_pkg.sv
rtl/core/sdpu_eval.sv
rtl/core/segment_descriptor_protection_unit.sv
rtl/core/sdpu_checker.sv
dv/tb.sv
